// ===== sv/two_axis_pid_servo_controller_macros.svh =====
// Assertion helpers shared by the servo controller modules.
`ifndef TWO_AXIS_PID_SERVO_CONTROLLER_MACROS_SVH
`define TWO_AXIS_PID_SERVO_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tapsc_pkg.sv =====
`timescale 1ns / 1ps

package tapsc_pkg;

    // Field widths.
    localparam int FRAME_BITS  = 13;
    localparam int COORD_BITS  = 12;
    localparam int TARGET_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int ERR_BITS    = 24;
    localparam int INTEG_BITS  = 40;

    // Stream word layout.
    localparam int FW_LSB     = 0;
    localparam int FH_LSB     = FW_LSB + FRAME_BITS;
    localparam int PX_LSB     = FH_LSB + FRAME_BITS;
    localparam int PY_LSB     = PX_LSB + COORD_BITS;
    localparam int TX_LSB     = PY_LSB + COORD_BITS;
    localparam int TY_LSB     = TX_LSB + TARGET_BITS;
    localparam int IN_USED_W  = TY_LSB + TARGET_BITS;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 2 * COORD_BITS;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Divider retires two quotient bits per step over a 32-bit dividend.
    localparam int DIV_STEPS = 16;
    // Wide operands are split into a signed upper part and this many low bits.
    localparam int MUL_SPLIT = 24;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_SERVO_LO  = 3'd3,
        CFG_SERVO_HI  = 3'd4,
        CFG_SERVO_CTR = 3'd5,
        CFG_STEP      = 3'd6,
        CFG_STEP_RCP  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0]     gain_p;
        logic signed [15:0]     gain_i;
        logic signed [15:0]     gain_d;
        logic [COORD_BITS-1:0]  servo_lo;
        logic [COORD_BITS-1:0]  servo_hi;
        logic [COORD_BITS-1:0]  servo_ctr;
        logic [15:0]            step;
        logic [15:0]            step_rcp;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        gain_p:    16'sd256,
        gain_i:    16'sd256,
        gain_d:    16'sd256,
        servo_lo:  12'd0,
        servo_hi:  12'd4095,
        servo_ctr: 12'd2048,
        step:      16'd256,
        step_rcp:  16'd256
    };

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_LATCH,
        ALU_CLEAR,
        ALU_T_FIN,
        ALU_DIV_LOAD,
        ALU_DIV_STEP,
        ALU_P_FIN,
        ALU_ERR,
        ALU_EI_TRUNC,
        ALU_INTEG,
        ALU_DIFF,
        ALU_DER,
        ALU_SUM_TRUNC,
        ALU_SUM_CENTER,
        ALU_CLAMP
    } t_alu;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_TGT,
        MUL_POS,
        MUL_EI,
        MUL_D,
        MUL_GP,
        MUL_GD_LO,
        MUL_GD_HI,
        MUL_GI_LO,
        MUL_GI_HI
    } t_mul;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_SET,
        ACC_ADD,
        ACC_ADD_HI
    } t_acc;

    typedef struct packed {
        t_alu alu;
        t_mul mul;
        t_acc acc;
        logic axis;
        logic load_out;
    } t_cmd;

endpackage

// ===== sv/tapsc_ctrl.sv =====
`timescale 1ns / 1ps
`include "two_axis_pid_servo_controller_macros.svh"

module tapsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_clear,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output tapsc_pkg::t_cmd o_cmd
);
    import tapsc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_TGT_MUL,
        S_TGT_FIN,
        S_POS_MUL,
        S_DIV_LOAD,
        S_DIV,
        S_POS_FIN,
        S_ERR,
        S_EI_MUL,
        S_EI_TRUNC,
        S_INTEG,
        S_DIFF,
        S_D_MUL,
        S_DER,
        S_SUM_P,
        S_SUM_DLO,
        S_SUM_DHI,
        S_SUM_ILO,
        S_SUM_IHI,
        S_SUM_LAST,
        S_SUM_TRUNC,
        S_SUM_CENTER,
        S_CLAMP,
        S_FINISH
    } t_state;

    localparam int CNT_W = $clog2(DIV_STEPS);

    t_state             r_state;
    logic               r_axis;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    t_cmd               cmd;

    // Command decode: the datapath acts on these at the next edge.
    always_comb begin
        cmd = '{alu: ALU_NONE, mul: MUL_NONE, acc: ACC_HOLD, axis: r_axis, load_out: 1'b0};
        case (r_state)
            S_IDLE:       cmd.alu = ALU_LATCH;
            S_CLEAR:      cmd.alu = ALU_CLEAR;
            S_TGT_MUL:    cmd.mul = MUL_TGT;
            S_TGT_FIN:    cmd.alu = ALU_T_FIN;
            S_POS_MUL:    cmd.mul = MUL_POS;
            S_DIV_LOAD:   cmd.alu = ALU_DIV_LOAD;
            S_DIV:        cmd.alu = ALU_DIV_STEP;
            S_POS_FIN:    cmd.alu = ALU_P_FIN;
            S_ERR:        cmd.alu = ALU_ERR;
            S_EI_MUL:     cmd.mul = MUL_EI;
            S_EI_TRUNC:   cmd.alu = ALU_EI_TRUNC;
            S_INTEG:      cmd.alu = ALU_INTEG;
            S_DIFF:       cmd.alu = ALU_DIFF;
            S_D_MUL:      cmd.mul = MUL_D;
            S_DER:        cmd.alu = ALU_DER;
            S_SUM_P:      cmd.mul = MUL_GP;
            S_SUM_DLO: begin
                cmd.mul = MUL_GD_LO;
                cmd.acc = ACC_SET;
            end
            S_SUM_DHI: begin
                cmd.mul = MUL_GD_HI;
                cmd.acc = ACC_ADD;
            end
            S_SUM_ILO: begin
                cmd.mul = MUL_GI_LO;
                cmd.acc = ACC_ADD_HI;
            end
            S_SUM_IHI: begin
                cmd.mul = MUL_GI_HI;
                cmd.acc = ACC_ADD;
            end
            S_SUM_LAST:   cmd.acc = ACC_ADD_HI;
            S_SUM_TRUNC:  cmd.alu = ALU_SUM_TRUNC;
            S_SUM_CENTER: cmd.alu = ALU_SUM_CENTER;
            S_CLAMP:      cmd.alu = ALU_CLAMP;
            S_FINISH:     cmd.load_out = !r_out_valid || i_out_ready;
            default:      cmd.alu = ALU_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_axis  <= 1'b0;
                        r_state <= i_in_clear ? S_CLEAR : S_TGT_MUL;
                    end
                end
                S_CLEAR:      r_state <= S_FINISH;
                S_TGT_MUL:    r_state <= S_TGT_FIN;
                S_TGT_FIN:    r_state <= S_POS_MUL;
                S_POS_MUL:    r_state <= S_DIV_LOAD;
                S_DIV_LOAD:   r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_POS_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_POS_FIN:    r_state <= S_ERR;
                S_ERR:        r_state <= S_EI_MUL;
                S_EI_MUL:     r_state <= S_EI_TRUNC;
                S_EI_TRUNC:   r_state <= S_INTEG;
                S_INTEG:      r_state <= S_DIFF;
                S_DIFF:       r_state <= S_D_MUL;
                S_D_MUL:      r_state <= S_DER;
                S_DER:        r_state <= S_SUM_P;
                S_SUM_P:      r_state <= S_SUM_DLO;
                S_SUM_DLO:    r_state <= S_SUM_DHI;
                S_SUM_DHI:    r_state <= S_SUM_ILO;
                S_SUM_ILO:    r_state <= S_SUM_IHI;
                S_SUM_IHI:    r_state <= S_SUM_LAST;
                S_SUM_LAST:   r_state <= S_SUM_TRUNC;
                S_SUM_TRUNC:  r_state <= S_SUM_CENTER;
                S_SUM_CENTER: r_state <= S_CLAMP;
                S_CLAMP: begin
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= S_TGT_MUL;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (cmd.load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default:      r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != S_IDLE, "accepted word did not start work")
    `ASSERT_IMPL(a_cnt_only_div, i_clk, i_rst_n, r_cnt != '0, r_state == S_DIV, "divide counter running outside division")
    `ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, cmd.load_out, !r_out_valid || i_out_ready, "result overwritten before taken")

endmodule

// ===== sv/tapsc_datapath.sv =====
`timescale 1ns / 1ps
`include "two_axis_pid_servo_controller_macros.svh"

module tapsc_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tapsc_pkg::t_cmd                  i_cmd,
    input  tapsc_pkg::t_cfg                  i_cfg,
    input  logic [tapsc_pkg::IN_DATA_W-1:0]  i_in_data,
    output logic [tapsc_pkg::OUT_DATA_W-1:0] o_out_data
);
    import tapsc_pkg::*;

    localparam int PROD_W = 43;
    localparam int ACC_W  = 58;
    localparam int SUM_W  = 50;
    localparam int DVD_W  = 32;
    localparam int SVU_W  = COORD_BITS + FRAC_BITS + 1;

    localparam logic signed [35:0] ERR_MAX = 36'((64'sd1 <<< (ERR_BITS - 1)) - 64'sd1);
    localparam logic signed [35:0] ERR_MIN = -ERR_MAX - 36'sd1;
    localparam logic signed [INTEG_BITS:0] INT_MAX =
        (INTEG_BITS + 1)'((64'sd1 <<< (INTEG_BITS - 1)) - 64'sd1);
    localparam logic signed [INTEG_BITS:0] INT_MIN = -INT_MAX - (INTEG_BITS + 1)'(1);

    // Division by 2**k rounding toward zero.
    function automatic logic signed [PROD_W-1:0] f_trunc_prod(
        input logic signed [PROD_W-1:0] v, input int unsigned k);
        logic signed [PROD_W-1:0] bias;
        bias = v[PROD_W-1] ? ((PROD_W'(1) <<< k) - PROD_W'(1)) : '0;
        return (v + bias) >>> k;
    endfunction

    function automatic logic signed [ACC_W-1:0] f_trunc_acc(
        input logic signed [ACC_W-1:0] v, input int unsigned k);
        logic signed [ACC_W-1:0] bias;
        bias = v[ACC_W-1] ? ((ACC_W'(1) <<< k) - ACC_W'(1)) : '0;
        return (v + bias) >>> k;
    endfunction

    // Latched input word.
    logic [FRAME_BITS-1:0]         r_fw, r_fh;
    logic [COORD_BITS-1:0]         r_px, r_py;
    logic signed [TARGET_BITS-1:0] r_tx, r_ty;

    // Working registers.
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic [DVD_W-1:0]              r_dvd;
    logic [FRAME_BITS-1:0]         r_rem, r_dvs;
    logic                          r_neg;
    logic signed [25:0]            r_t;
    logic signed [34:0]            r_p;
    logic signed [ERR_BITS-1:0]    r_err;
    logic signed [33:0]            r_q;
    logic signed [32:0]            r_der;
    logic signed [SUM_W-1:0]       r_s;
    logic [COORD_BITS-1:0]         r_drive_x, r_drive_y;
    logic [COORD_BITS-1:0]         r_out_x, r_out_y;

    // Controller state that reset clears.
    logic signed [INTEG_BITS-1:0]  r_integ_x, r_integ_y;
    logic signed [ERR_BITS-1:0]    r_last_x, r_last_y;

    // Axis selection.
    logic [FRAME_BITS-1:0]         fsel;
    logic [COORD_BITS-1:0]         psel;
    logic signed [TARGET_BITS-1:0] tsel;
    logic signed [INTEG_BITS-1:0]  integ_sel;
    logic signed [ERR_BITS-1:0]    last_sel;

    assign fsel      = i_cmd.axis ? r_fh      : r_fw;
    assign psel      = i_cmd.axis ? r_py      : r_px;
    assign tsel      = i_cmd.axis ? r_ty      : r_tx;
    assign integ_sel = i_cmd.axis ? r_integ_y : r_integ_x;
    assign last_sel  = i_cmd.axis ? r_last_y  : r_last_x;

    // Servo limits in fixed point and the mapping span.
    logic signed [SVU_W-1:0]      lo_fx, hi_fx, ctr_fx;
    logic signed [COORD_BITS:0]   span;

    assign lo_fx  = $signed({1'b0, i_cfg.servo_lo,  {FRAC_BITS{1'b0}}});
    assign hi_fx  = $signed({1'b0, i_cfg.servo_hi,  {FRAC_BITS{1'b0}}});
    assign ctr_fx = $signed({1'b0, i_cfg.servo_ctr, {FRAC_BITS{1'b0}}});
    assign span   = $signed({1'b0, i_cfg.servo_hi}) - $signed({1'b0, i_cfg.servo_lo});

    // Shared multiplier: one product per cycle, registered.
    logic signed [16:0]       mul_a;
    logic signed [25:0]       mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul)
            MUL_TGT: begin
                mul_a = 17'(tsel) + 17'sd16384;
                mul_b = 26'(span);
            end
            MUL_POS: begin
                mul_a = $signed({5'b0, psel});
                mul_b = 26'(span);
            end
            MUL_EI: begin
                mul_a = $signed({1'b0, i_cfg.step});
                mul_b = 26'(r_err);
            end
            MUL_D: begin
                mul_a = $signed({1'b0, i_cfg.step_rcp});
                mul_b = 26'(r_q);
            end
            MUL_GP: begin
                mul_a = 17'(i_cfg.gain_p);
                mul_b = 26'(r_err);
            end
            MUL_GD_LO: begin
                mul_a = 17'(i_cfg.gain_d);
                mul_b = $signed({2'b0, r_der[MUL_SPLIT-1:0]});
            end
            MUL_GD_HI: begin
                mul_a = 17'(i_cfg.gain_d);
                mul_b = 26'($signed(r_der[32:MUL_SPLIT]));
            end
            MUL_GI_LO: begin
                mul_a = 17'(i_cfg.gain_i);
                mul_b = $signed({2'b0, integ_sel[MUL_SPLIT-1:0]});
            end
            MUL_GI_HI: begin
                mul_a = 17'(i_cfg.gain_i);
                mul_b = 26'($signed(integ_sel[INTEG_BITS-1:MUL_SPLIT]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Divider: two restoring steps per cycle.
    logic [FRAME_BITS:0]   rem_a, rem_b;
    logic                  ge_a, ge_b;
    logic [FRAME_BITS-1:0] rem_a2, rem_b2;
    logic [PROD_W-1:0]     prod_mag;

    assign rem_a    = {r_rem, r_dvd[DVD_W-1]};
    assign ge_a     = rem_a >= {1'b0, r_dvs};
    assign rem_a2   = ge_a ? FRAME_BITS'(rem_a - {1'b0, r_dvs}) : FRAME_BITS'(rem_a);
    assign rem_b    = {rem_a2, r_dvd[DVD_W-2]};
    assign ge_b     = rem_b >= {1'b0, r_dvs};
    assign rem_b2   = ge_b ? FRAME_BITS'(rem_b - {1'b0, r_dvs}) : FRAME_BITS'(rem_b);
    assign prod_mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);

    // Error, integral and clamp helpers.
    logic signed [35:0]           err_diff;
    logic signed [INTEG_BITS:0]   integ_sum;
    logic signed [34:0]           quot_s;
    logic signed [SUM_W-1:0]      lo_s, hi_s, clamp_v;

    assign err_diff  = 36'(r_t) - 36'(r_p);
    assign integ_sum = (INTEG_BITS + 1)'(integ_sel) + (INTEG_BITS + 1)'(r_q);
    assign quot_s    = $signed({3'b0, r_dvd});
    assign lo_s      = SUM_W'(lo_fx);
    assign hi_s      = SUM_W'(hi_fx);

    // Raise to the low limit, then lower to the high limit.
    always_comb begin
        if (r_s < lo_s) begin
            clamp_v = (lo_s > hi_s) ? hi_s : lo_s;
        end else if (r_s > hi_s) begin
            clamp_v = hi_s;
        end else begin
            clamp_v = r_s;
        end
    end

    logic signed [INTEG_BITS-1:0] integ_next;
    assign integ_next = (integ_sum > INT_MAX) ? INTEG_BITS'(INT_MAX) :
                        (integ_sum < INT_MIN) ? INTEG_BITS'(INT_MIN) :
                        INTEG_BITS'(integ_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_x <= '0;
            r_integ_y <= '0;
            r_last_x  <= '0;
            r_last_y  <= '0;
        end else begin
            case (i_cmd.alu)
                ALU_CLEAR: begin
                    r_integ_x <= '0;
                    r_integ_y <= '0;
                    r_last_x  <= '0;
                    r_last_y  <= '0;
                end
                ALU_INTEG: begin
                    if (i_cmd.axis) begin
                        r_integ_y <= integ_next;
                    end else begin
                        r_integ_x <= integ_next;
                    end
                end
                ALU_DER: begin
                    if (i_cmd.axis) begin
                        r_last_y <= r_err;
                    end else begin
                        r_last_x <= r_err;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;

        case (i_cmd.acc)
            ACC_SET:    r_acc <= ACC_W'(r_prod);
            ACC_ADD:    r_acc <= r_acc + ACC_W'(r_prod);
            ACC_ADD_HI: r_acc <= r_acc + (ACC_W'(r_prod) <<< MUL_SPLIT);
            default:    r_acc <= r_acc;
        endcase

        if (i_cmd.load_out) begin
            r_out_x <= r_drive_x;
            r_out_y <= r_drive_y;
        end

        case (i_cmd.alu)
            ALU_LATCH: begin
                r_fw <= i_in_data[FW_LSB +: FRAME_BITS];
                r_fh <= i_in_data[FH_LSB +: FRAME_BITS];
                r_px <= i_in_data[PX_LSB +: COORD_BITS];
                r_py <= i_in_data[PY_LSB +: COORD_BITS];
                r_tx <= $signed(i_in_data[TX_LSB +: TARGET_BITS]);
                r_ty <= $signed(i_in_data[TY_LSB +: TARGET_BITS]);
            end
            ALU_CLEAR: begin
                r_drive_x <= i_cfg.servo_ctr;
                r_drive_y <= i_cfg.servo_ctr;
            end
            ALU_T_FIN: begin
                r_t <= 26'(f_trunc_prod(r_prod, 7) + PROD_W'(lo_fx));
            end
            ALU_DIV_LOAD: begin
                r_dvd <= {prod_mag[DVD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
                r_neg <= r_prod[PROD_W-1];
                r_rem <= '0;
                r_dvs <= (fsel == '0) ? FRAME_BITS'(1) : fsel;
            end
            ALU_DIV_STEP: begin
                r_rem <= rem_b2;
                r_dvd <= {r_dvd[DVD_W-3:0], ge_a, ge_b};
            end
            ALU_P_FIN: begin
                r_p <= r_neg ? (35'(lo_fx) - quot_s) : (35'(lo_fx) + quot_s);
            end
            ALU_ERR: begin
                r_err <= (err_diff > ERR_MAX) ? ERR_BITS'(ERR_MAX) :
                         (err_diff < ERR_MIN) ? ERR_BITS'(ERR_MIN) :
                         ERR_BITS'(err_diff);
            end
            ALU_EI_TRUNC: r_q <= 34'(f_trunc_prod(r_prod, FRAC_BITS));
            ALU_DIFF:     r_q <= 34'(r_err) - 34'(last_sel);
            ALU_DER:      r_der <= 33'(f_trunc_prod(r_prod, FRAC_BITS));
            ALU_SUM_TRUNC: r_s <= SUM_W'(f_trunc_acc(r_acc, FRAC_BITS));
            ALU_SUM_CENTER: r_s <= r_s + SUM_W'(ctr_fx);
            ALU_CLAMP: begin
                if (i_cmd.axis) begin
                    r_drive_y <= clamp_v[FRAC_BITS +: COORD_BITS];
                end else begin
                    r_drive_x <= clamp_v[FRAC_BITS +: COORD_BITS];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_data = {r_out_y, r_out_x};

    `ASSERT_IMPL(a_rem_below_divisor, i_clk, i_rst_n, i_cmd.alu == ALU_DIV_STEP, r_rem < r_dvs, "division remainder reached divisor")

endmodule

// ===== sv/two_axis_pid_servo_controller.sv =====
`timescale 1ns / 1ps

// Two-axis PID servo controller.
// Input stream: one word per camera frame. tuser[0] is the command (0 update,
// 1 clear). tdata carries frame size, measured pixel position and target.
// Output stream: one word per input word with the X and Y servo commands.
// Configuration: gains, servo limits, center and step time are written on the
// cfg port while the block is idle; each write takes effect at once.
// Schedule: an update word runs both axes in turn on one shared multiplier,
// one accumulator and a divider that retires two quotient bits per cycle.
// Each axis includes the pixel scaling divide. A new word is accepted only
// once the previous one has been loaded into the output register. A clear
// word goes straight from the clear state to the finish state.
// The output word sits in its own register; if the receiver stalls, the
// next word is still computed and waits in the finish state until the
// output register is free. Reset restores the default configuration and
// zeroes both integrals and both stored errors.

module two_axis_pid_servo_controller (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input words.
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // From bit 0: frame_width[13], frame_height[13], pos_x[12], pos_y[12],
    // target_x[16], target_y[16], then zero fill.
    input  logic [tapsc_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // command[1]: 0 update, 1 clear.
    input  logic [tapsc_pkg::IN_USER_W-1:0]       i_s_axis_tuser,
    // Output words.
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // From bit 0: drive_x[12], drive_y[12].
    output logic [tapsc_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // Configuration writes.
    input  logic                                  i_cfg_wen,
    input  logic [tapsc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [tapsc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import tapsc_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;

    // Configuration register file; servo values keep the low bits only.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wen) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_GAIN_P:    r_cfg.gain_p    <= $signed(i_cfg_wdata);
                CFG_GAIN_I:    r_cfg.gain_i    <= $signed(i_cfg_wdata);
                CFG_GAIN_D:    r_cfg.gain_d    <= $signed(i_cfg_wdata);
                CFG_SERVO_LO:  r_cfg.servo_lo  <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_SERVO_HI:  r_cfg.servo_hi  <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_SERVO_CTR: r_cfg.servo_ctr <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_STEP:      r_cfg.step      <= i_cfg_wdata;
                CFG_STEP_RCP:  r_cfg.step_rcp  <= i_cfg_wdata;
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    tapsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_clear  (i_s_axis_tuser[0]),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    tapsc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg      (r_cfg),
        .i_in_data  (i_s_axis_tdata),
        .o_out_data (o_m_axis_tdata)
    );

endmodule
